[rtl/core/ils_pkg.sv]
// Shared types, constants and helpers for the indexed list store.
// Used by ils_ctrl, ils_datapath and indexed_list_store.
package ils_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_POP_FRONT  = 3'd1,
        MODE_PUSH_BACK  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_READ       = 3'd6,
        MODE_CLEAR      = 3'd7
    } ils_mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } ils_status_t;

    typedef enum logic [1:0] {
        RD_POS   = 2'd0,
        RD_BELOW = 2'd1,
        RD_ABOVE = 2'd2
    } ils_rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT = 2'd0,
        WR_PUT   = 2'd1,
        WR_FRONT = 2'd2,
        WR_BACK  = 2'd3
    } ils_wr_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_PUT,
        S_RDWAIT,
        S_RESP
    } ils_state_t;

    typedef struct packed {
        logic        load;
        logic        init_shift;
        logic        rd_en;
        ils_rd_sel_t rd_sel;
        logic        wr_en;
        ils_wr_sel_t wr_sel;
        logic        idx_inc;
        logic        idx_dec;
        logic        head_inc;
        logic        head_dec;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        cnt_clr;
        logic        set_err;
        logic        cap_read;
        logic        out_load;
    } ils_cmd_t;

    typedef struct packed {
        ils_mode_t mode;
        logic      err;
        logic      ins_at_end;
        logic      rm_at_end;
        logic      up_last;
        logic      dn_last;
    } ils_sts_t;

    // Map a logical slot onto the circular buffer; head + slot stays below 2*CAPACITY.
    function automatic logic [ADDR_W-1:0] ils_phys(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0]  slot);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(slot);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

[rtl/core/ils_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/ils_datapath.sv]
// Datapath of the indexed list store: request latch, head and count, entry RAM,
// result registers. Depends on ils_pkg and ils_ram.
module ils_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ils_pkg::ils_cmd_t                      cmd,
    output ils_pkg::ils_sts_t                      sts,
    input  logic [ils_pkg::MODE_W-1:0]             mode,
    input  logic signed [ils_pkg::DATA_W-1:0]      value,
    input  logic [ils_pkg::POS_W-1:0]              position,
    output logic signed [ils_pkg::DATA_W-1:0]      read_value,
    output logic [ils_pkg::STAT_W-1:0]             status,
    output logic [ils_pkg::CNT_W-1:0]              count
);
    import ils_pkg::*;

    ils_mode_t          mode_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   tgt_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [DATA_W-1:0]  res_val_reg;
    ils_status_t        res_st_reg;
    ils_status_t        st_calc;
    logic [DATA_W-1:0]  rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  head_dec;
    logic [ADDR_W-1:0]  head_inc;
    logic [CNT_W-1:0]   pos_m1;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic               pos_bad_ins;
    logic               pos_bad_rd;
    logic               full;

    assign pos_m1   = CNT_W'(pos_reg - POS_W'(1));
    assign pos_x    = CMP_W'(pos_reg);
    assign cnt_x    = CMP_W'(cnt_reg);
    assign full     = (cnt_x >= CMP_W'(CAPACITY));
    assign head_dec = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - ADDR_W'(1);
    assign head_inc = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + ADDR_W'(1);

    assign pos_bad_ins = (pos_reg == '0) || (pos_x > cnt_x + CMP_W'(1));
    assign pos_bad_rd  = (pos_reg == '0) || (pos_x > cnt_x);

    always_comb
    begin
        st_calc = ST_OK;
        unique case (mode_reg)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    st_calc = ST_FULL;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (cnt_reg == '0)
                begin
                    st_calc = ST_EMPTY;
                end
            end
            MODE_INSERT:
            begin
                if (pos_bad_ins)
                begin
                    st_calc = ST_BADPOS;
                end
                else if (full)
                begin
                    st_calc = ST_FULL;
                end
            end
            MODE_REMOVE, MODE_READ:
            begin
                if (pos_bad_rd)
                begin
                    st_calc = ST_BADPOS;
                end
            end
            MODE_CLEAR:
            begin
                st_calc = ST_OK;
            end
            default:
            begin
                st_calc = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.err        = (st_calc != ST_OK);
        sts.ins_at_end = (pos_m1 == cnt_reg);
        sts.rm_at_end  = (pos_x == cnt_x);
        sts.up_last    = ((idx_reg - CNT_W'(1)) == tgt_reg);
        sts.dn_last    = ((CMP_W'(idx_reg) + CMP_W'(2)) == cnt_x);
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_POS:   rd_addr = ils_phys(head_reg, pos_m1);
            RD_BELOW: rd_addr = ils_phys(head_reg, idx_reg - CNT_W'(1));
            RD_ABOVE: rd_addr = ils_phys(head_reg, idx_reg + CNT_W'(1));
            default:  rd_addr = ils_phys(head_reg, pos_m1);
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = ils_phys(head_reg, idx_reg);
                wr_data = rd_data;
            end
            WR_PUT:
            begin
                wr_addr = ils_phys(head_reg, tgt_reg);
                wr_data = val_reg;
            end
            WR_FRONT:
            begin
                wr_addr = head_dec;
                wr_data = val_reg;
            end
            WR_BACK:
            begin
                wr_addr = ils_phys(head_reg, cnt_reg);
                wr_data = val_reg;
            end
            default:
            begin
                wr_addr = ils_phys(head_reg, idx_reg);
                wr_data = rd_data;
            end
        endcase
    end

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_dec)
        begin
            head_next = head_dec;
        end
        else if (cmd.head_inc)
        begin
            head_next = head_inc;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Request latch, shift indexes and result holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= ils_mode_t'(mode);
            val_reg     <= value;
            pos_reg     <= position;
            res_st_reg  <= ST_OK;
            res_val_reg <= '0;
        end
        if (cmd.set_err)
        begin
            res_st_reg <= st_calc;
        end
        if (cmd.cap_read)
        begin
            res_val_reg <= rd_data;
        end
        if (cmd.init_shift)
        begin
            idx_reg <= (mode_reg == MODE_INSERT) ? cnt_reg : pos_m1;
            tgt_reg <= pos_m1;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            read_value <= res_val_reg;
            status     <= res_st_reg;
            count      <= cnt_reg;
        end
    end

endmodule

[rtl/core/ils_ctrl.sv]
// Controller of the indexed list store: request sequencing and handshakes.
// Depends on ils_pkg.
module ils_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ils_pkg::ils_sts_t sts,
    output ils_pkg::ils_cmd_t cmd
);
    import ils_pkg::*;

    ils_state_t state_reg;
    ils_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.err)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    unique case (sts.mode) inside
                        MODE_READ:
                        begin
                            state_next = S_RDWAIT;
                        end
                        MODE_INSERT:
                        begin
                            state_next = sts.ins_at_end ? S_PUT : S_SHUP_RD;
                        end
                        MODE_REMOVE:
                        begin
                            state_next = sts.rm_at_end ? S_RESP : S_SHDN_RD;
                        end
                        MODE_PUSH_FRONT, MODE_POP_FRONT, MODE_PUSH_BACK, MODE_POP_BACK,
                        MODE_CLEAR:
                        begin
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SHUP_RD: state_next = S_SHUP_WR;
            S_SHUP_WR: state_next = sts.up_last ? S_PUT : S_SHUP_RD;
            S_SHDN_RD: state_next = S_SHDN_WR;
            S_SHDN_WR: state_next = sts.dn_last ? S_RESP : S_SHDN_RD;
            S_PUT:     state_next = S_RESP;
            S_RDWAIT:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_POS;
        cmd.wr_sel = WR_SHIFT;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                if (sts.err)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    unique case (sts.mode)
                        MODE_PUSH_FRONT:
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = WR_FRONT;
                            cmd.head_dec = 1'b1;
                            cmd.cnt_inc  = 1'b1;
                        end
                        MODE_PUSH_BACK:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_BACK;
                            cmd.cnt_inc = 1'b1;
                        end
                        MODE_POP_FRONT:
                        begin
                            cmd.head_inc = 1'b1;
                            cmd.cnt_dec  = 1'b1;
                        end
                        MODE_POP_BACK:
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        MODE_INSERT:
                        begin
                            cmd.init_shift = 1'b1;
                        end
                        MODE_REMOVE:
                        begin
                            // removing the last entry needs no shift
                            cmd.init_shift = !sts.rm_at_end;
                            cmd.cnt_dec    = sts.rm_at_end;
                        end
                        MODE_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.cnt_clr = 1'b1;
                        end
                        default:
                        begin
                            cmd.cnt_clr = 1'b0;
                        end
                    endcase
                end
            end
            S_SHUP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_BELOW;
            end
            S_SHUP_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_dec = 1'b1;
            end
            S_SHDN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ABOVE;
            end
            S_SHDN_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_inc = 1'b1;
                cmd.cnt_dec = sts.dn_last;
            end
            S_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_PUT;
                cmd.cnt_inc = 1'b1;
            end
            S_RDWAIT:
            begin
                cmd.cap_read = 1'b1;
            end
            S_RESP:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/indexed_list_store.sv]
// Indexed list store: a bounded list of up to 1024 signed 32-bit values with
// 1-based positions, kept in a circular buffer in one RAM so that pushes and
// pops at either end take a fixed time. Each request gives one result with a
// status, the count after the request and, for a read, the value. Push, pop,
// clear and any rejected request go from the check state to the response state;
// a read passes a wait state for the registered RAM data; an insert or remove
// first shifts the later entries, and each moved entry costs one RAM
// read and one RAM write. One request is in work at a time; the next one is
// taken when the block is back in idle, even while the last result waits.
// Depends on ils_pkg, ils_ctrl, ils_datapath and ils_ram.
module indexed_list_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ils_pkg::MODE_W-1:0]        mode,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    input  logic [ils_pkg::POS_W-1:0]         position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ils_pkg::DATA_W-1:0] read_value,
    output logic [ils_pkg::STAT_W-1:0]        status,
    output logic [ils_pkg::CNT_W-1:0]         count
);
    import ils_pkg::*;

    ils_cmd_t cmd;
    ils_sts_t sts;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ils_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .mode       (mode),
        .value      (value),
        .position   (position),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

endmodule

[tb/tb_indexed_list_store.sv]
// Self-checking testbench for indexed_list_store: drives list requests over
// valid/ready, predicts every response with a local list model and compares.
// Depends on ils_pkg and the indexed_list_store RTL.
module tb_indexed_list_store;
    import ils_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int LIMIT_CYC   = 2_000_000;
    localparam int TAIL_CYC    = 64;
    localparam int LEN_CEILING = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        ils_mode_t                mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } list_req_t;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        ils_status_t              status;
        logic [CNT_W-1:0]         count;
    } list_resp_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;

    indexed_list_store dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Local list model
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;
    int                       peak_len = 0;

    list_req_t  req_backlog[$];
    list_resp_t expected_resp[$];
    list_req_t  cur_req;
    int         gen_len = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_accepted     = 0;
    int n_checked      = 0;
    int n_mismatch     = 0;
    int n_full_seen    = 0;

    function automatic ils_status_t request_status(int cnt, ils_mode_t m, int pos);
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
                return (cnt >= CAPACITY) ? ST_FULL : ST_OK;
            MODE_POP_FRONT, MODE_POP_BACK:
                return (cnt == 0) ? ST_EMPTY : ST_OK;
            MODE_INSERT:
            begin
                if (pos < 1 || pos > cnt + 1)
                    return ST_BADPOS;
                return (cnt >= CAPACITY) ? ST_FULL : ST_OK;
            end
            MODE_REMOVE, MODE_READ:
                return (pos < 1 || pos > cnt) ? ST_BADPOS : ST_OK;
            default:
                return ST_OK;
        endcase
    endfunction

    function automatic int count_next(int cnt, ils_mode_t m, ils_status_t st);
        if (m == MODE_CLEAR)
            return 0;
        if (st != ST_OK)
            return cnt;
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT:
                return cnt + 1;
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE:
                return cnt - 1;
            default:
                return cnt;
        endcase
    endfunction

    // Update the list model with one accepted request and queue its response.
    task automatic apply_request(input list_req_t req);
        ils_status_t              st;
        logic signed [DATA_W-1:0] rd;
        int                       open_slot;
        int                       drop_slot;
        list_resp_t               resp;
        st        = request_status(list_len, req.mode, int'(req.position));
        rd        = '0;
        open_slot = -1;
        drop_slot = -1;
        if (st == ST_OK)
        begin
            case (req.mode)
                MODE_PUSH_FRONT: open_slot = 0;
                MODE_PUSH_BACK:  open_slot = list_len;
                MODE_INSERT:     open_slot = int'(req.position) - 1;
                MODE_POP_FRONT:  drop_slot = 0;
                MODE_POP_BACK:   drop_slot = list_len - 1;
                MODE_REMOVE:     drop_slot = int'(req.position) - 1;
                MODE_READ:       rd = list_mem[int'(req.position) - 1];
                default:         ;
            endcase
        end
        if (open_slot >= 0)
        begin
            for (int k = list_len; k > open_slot; k--)
                list_mem[k] = list_mem[k-1];
            list_mem[open_slot] = req.value;
        end
        if (drop_slot >= 0)
        begin
            for (int k = drop_slot; k < list_len - 1; k++)
                list_mem[k] = list_mem[k+1];
        end
        list_len = count_next(list_len, req.mode, st);
        if (list_len > peak_len)
            peak_len = list_len;
        if (st == ST_FULL)
            n_full_seen++;
        resp.read_value = rd;
        resp.status     = st;
        resp.count      = CNT_W'(list_len);
        expected_resp.push_back(resp);
    endtask

    // Queue a request and track the count it will leave behind.
    task automatic queue_request(input ils_mode_t m, input logic [DATA_W-1:0] v,
                                 input int pos);
        list_req_t req;
        req.mode     = m;
        req.value    = v;
        req.position = POS_W'(pos);
        req_backlog.push_back(req);
        gen_len = count_next(gen_len, m, request_status(gen_len, m, int'(req.position)));
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_traffic(input int n_items);
        ils_mode_t m;
        int        lim;
        int        r;
        int        pos;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                m = MODE_CLEAR;
            else
                m = ils_mode_t'($urandom_range(0, 6));
            // Steer the length: shrink above the ceiling, grow when nearly empty.
            if (gen_len > LEN_CEILING)
            begin
                if (m == MODE_PUSH_FRONT)     m = MODE_POP_FRONT;
                else if (m == MODE_PUSH_BACK) m = MODE_POP_BACK;
                else if (m == MODE_INSERT)    m = MODE_REMOVE;
            end
            else if (gen_len < 3 && $urandom_range(0, 3) != 0)
            begin
                if (m == MODE_POP_FRONT)      m = MODE_PUSH_FRONT;
                else if (m == MODE_POP_BACK)  m = MODE_PUSH_BACK;
                else if (m == MODE_REMOVE)    m = MODE_INSERT;
            end
            lim = (m == MODE_INSERT) ? gen_len + 1 : gen_len;
            r   = $urandom_range(0, 99);
            if (r < 75 && lim >= 1)
                pos = $urandom_range(1, lim);
            else if (r < 84)
                pos = 0;
            else if (r < 92)
                pos = lim + 1;
            else
                pos = $urandom_range(0, 2047);
            queue_request(m, pick_value(), pos);
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || in_valid || expected_resp.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_pacing(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Driver: present the next queued transaction once the slot is free.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request(cur_req);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req  = req_backlog.pop_front();
                    in_valid <= 1'b1;
                    mode     <= cur_req.mode;
                    value    <= cur_req.value;
                    position <= cur_req.position;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each response transaction against the oldest prediction.
    always @(posedge clk)
    begin
        list_resp_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resp.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected response: rd=%0d st=%0d cnt=%0d",
                                 read_value, status, count);
                end
                else
                begin
                    want = expected_resp.pop_front();
                    n_checked++;
                    if (read_value !== want.read_value || status !== want.status ||
                        count !== want.count)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display({"mismatch on response %0d: exp rd=%0d st=%0d ",
                                      "cnt=%0d, got rd=%0d st=%0d cnt=%0d"},
                                     n_checked, want.read_value, want.status, want.count,
                                     read_value, status, count);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYC);
        $display("tb_indexed_list_store: done, errors");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list corner cases, value extremes, ends and middle.
        set_pacing(0, 0);
        queue_request(MODE_POP_FRONT, $urandom(), 0);
        queue_request(MODE_POP_BACK, $urandom(), 2047);
        queue_request(MODE_REMOVE, $urandom(), 1);
        queue_request(MODE_READ, $urandom(), 0);
        queue_request(MODE_READ, $urandom(), 1);
        queue_request(MODE_INSERT, 32'h1234_5678, 0);
        queue_request(MODE_INSERT, 32'h1234_5678, 2);
        queue_request(MODE_INSERT, 32'h7fff_ffff, 1);
        queue_request(MODE_PUSH_FRONT, 32'h8000_0000, 2047);
        queue_request(MODE_PUSH_BACK, 32'h0000_0000, 0);
        queue_request(MODE_PUSH_BACK, 32'hffff_ffff, 1024);
        queue_request(MODE_INSERT, 32'h5555_5555, 3);
        for (int p = 1; p <= 5; p++)
            queue_request(MODE_READ, $urandom(), p);
        queue_request(MODE_READ, $urandom(), 6);
        queue_request(MODE_READ, $urandom(), 2047);
        queue_request(MODE_REMOVE, $urandom(), 5);
        queue_request(MODE_REMOVE, $urandom(), 1);
        queue_request(MODE_REMOVE, $urandom(), 2);
        queue_request(MODE_POP_FRONT, $urandom(), 0);
        queue_request(MODE_CLEAR, 32'hdead_beef, 1365);
        queue_request(MODE_READ, $urandom(), 1);
        wait_drained();

        // Random traffic under each pacing mix.
        set_pacing(0, 0);
        random_traffic(115);
        wait_drained();
        set_pacing(84, 0);
        random_traffic(110);
        wait_drained();
        set_pacing(0, 84);
        random_traffic(110);
        wait_drained();
        set_pacing(13, 13);
        random_traffic(115);
        wait_drained();

        // Let any stray response surface before closing.
        set_pacing(0, 0);
        repeat (TAIL_CYC) @(negedge clk);

        $display("covered %0d requests across four pacing mixes, %0d responses checked",
                 n_accepted, n_checked);
        $display("peak list length %0d, %0d requests refused as full", peak_len, n_full_seen);
        if (n_mismatch == 0 && expected_resp.size() == 0)
            $display("tb_indexed_list_store: done, clean");
        else
            $display("tb_indexed_list_store: done, errors");
        $finish;
    end

endmodule
